// ===== src/mhtc_pkg.sv =====
// ----------------------------------------------------------------------------
// mhtc_pkg
// Shared types, constants and the signature classifier for the media header
// type classifier.
// ----------------------------------------------------------------------------
package mhtc_pkg;

    localparam int HEADER_BYTES = 64;
    localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
    localparam int HEAD_LEN     = 12;
    localparam int HEAD_IDX_W   = $clog2(HEAD_LEN);
    localparam int WIN_LEN      = 7;

    localparam logic [1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLS_VIDEO   = 2'd1;
    localparam logic [1:0] CLS_PHOTO   = 2'd2;
    localparam logic [1:0] CLS_AUDIO   = 2'd3;

    // ogg marker bits
    localparam int OGG_AUDIO_BIT = 0;
    localparam int OGG_VIDEO_BIT = 1;

    // signatures, first byte in the top bits
    localparam logic [63:0] SIG_OPUS   = 64'h4f70_7573_4865_6164;
    localparam logic [55:0] SIG_VORBIS = 56'h01_766f_7262_6973;
    localparam logic [55:0] SIG_THEORA = 56'h80_7468_656f_7261;
    localparam logic [31:0] SIG_RIFF   = 32'h5249_4646;
    localparam logic [31:0] SIG_WEBP   = 32'h5745_4250;
    localparam logic [31:0] SIG_WAVE   = 32'h5741_5645;
    localparam logic [31:0] SIG_AVI    = 32'h4156_4920;
    localparam logic [31:0] SIG_FTYP   = 32'h6674_7970;
    localparam logic [31:0] SIG_HEIC   = 32'h6865_6963;
    localparam logic [31:0] SIG_HEIX   = 32'h6865_6978;
    localparam logic [31:0] SIG_MIF1   = 32'h6d69_6631;
    localparam logic [31:0] SIG_HEIM   = 32'h6865_696d;
    localparam logic [31:0] SIG_HEIS   = 32'h6865_6973;
    localparam logic [31:0] SIG_AVIF   = 32'h6176_6966;
    localparam logic [31:0] SIG_AVIS   = 32'h6176_6973;
    localparam logic [31:0] SIG_M4A    = 32'h4d34_4120;
    localparam logic [31:0] SIG_OGGS   = 32'h4f67_6753;
    localparam logic [31:0] SIG_PNG    = 32'h8950_4e47;
    localparam logic [31:0] SIG_GIF    = 32'h4749_4638;
    localparam logic [31:0] SIG_TIFF_LE = 32'h4949_2a00;
    localparam logic [31:0] SIG_TIFF_BE = 32'h4d4d_002a;
    localparam logic [31:0] SIG_FLV    = 32'h464c_5601;
    localparam logic [31:0] SIG_EBML   = 32'h1a45_dfa3;
    localparam logic [23:0] SIG_JPEG   = 24'hffd8ff;
    localparam logic [15:0] SIG_BMP    = 16'h424d;
    localparam logic [7:0]  SIG_TS     = 8'h47;

    typedef logic [HEAD_LEN-1:0][7:0] t_head;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
        logic [1:0] ext_class;
    } t_item;

    typedef struct packed {
        logic [1:0] media_class;
        logic       from_content;
    } t_result;

    function automatic logic [1:0] classify(input t_head h, input logic [CNT_W-1:0] n,
                                            input logic [1:0] ogg);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic        n12;
        logic [1:0]  c;
        w0  = {h[0], h[1], h[2], h[3]};
        w1  = {h[4], h[5], h[6], h[7]};
        w2  = {h[8], h[9], h[10], h[11]};
        n12 = (n >= CNT_W'(HEAD_LEN));
        c   = CLS_UNKNOWN;
        if (n < CNT_W'(4)) begin
            c = CLS_UNKNOWN;
        end else if (w0[31:8] == SIG_JPEG || w0 == SIG_PNG || w0 == SIG_GIF
                     || w0[31:16] == SIG_BMP || w0 == SIG_TIFF_LE
                     || w0 == SIG_TIFF_BE) begin
            c = CLS_PHOTO;
        end else if (w0 == SIG_FLV || w0 == SIG_EBML || w0[31:24] == SIG_TS) begin
            c = CLS_VIDEO;
        end else if (n12 && w0 == SIG_RIFF && w2 == SIG_WEBP) begin
            c = CLS_PHOTO;
        end else if (n12 && w0 == SIG_RIFF && w2 == SIG_WAVE) begin
            c = CLS_AUDIO;
        end else if (n12 && w0 == SIG_RIFF && w2 == SIG_AVI) begin
            c = CLS_VIDEO;
        end else if (n12 && w1 == SIG_FTYP) begin
            if (w2 == SIG_HEIC || w2 == SIG_HEIX || w2 == SIG_MIF1 || w2 == SIG_HEIM
                || w2 == SIG_HEIS || w2 == SIG_AVIF || w2 == SIG_AVIS) begin
                c = CLS_PHOTO;
            end else if (w2 == SIG_M4A) begin
                c = CLS_AUDIO;
            end else begin
                c = CLS_VIDEO;
            end
        end else if (w0 == SIG_OGGS) begin
            if (ogg[OGG_AUDIO_BIT]) begin
                c = CLS_AUDIO;
            end else if (ogg[OGG_VIDEO_BIT]) begin
                c = CLS_VIDEO;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/mhtc_in_stage.sv =====
// ----------------------------------------------------------------------------
// mhtc_in_stage
// Input register; holds one transaction until the tracker consumes it.
// ----------------------------------------------------------------------------
module mhtc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mhtc_pkg::t_item i_item,
    input  logic            i_out_free,
    output logic            o_valid,
    output logic            o_fire,
    output mhtc_pkg::t_item o_item
);

    logic            r_valid;
    mhtc_pkg::t_item r_item;

    // a last item waits only while the result register is still full
    assign o_fire  = r_valid && (!r_item.last || i_out_free);
    assign o_ready = !r_valid || o_fire;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/mhtc_tracker.sv =====
// ----------------------------------------------------------------------------
// mhtc_tracker
// Keeps the header bytes, byte count and ogg markers, and classifies the file
// when its last item is consumed.
// ----------------------------------------------------------------------------
module mhtc_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mhtc_pkg::t_item   i_item,
    output logic              o_res_valid,
    output mhtc_pkg::t_result o_res
);

    mhtc_pkg::t_head                     r_head;
    mhtc_pkg::t_head                     n_head;
    logic [mhtc_pkg::CNT_W-1:0]          r_count;
    logic [mhtc_pkg::CNT_W-1:0]          n_count;
    logic [mhtc_pkg::WIN_LEN*8-1:0]      r_win;
    logic [mhtc_pkg::WIN_LEN*8-1:0]      n_win;
    logic [1:0]                          r_ogg;
    logic [1:0]                          n_ogg;
    logic [mhtc_pkg::WIN_LEN*8+7:0]      w_full;
    logic                                w_take;
    logic [1:0]                          w_class;

    assign w_take = i_fire && i_item.has_byte
                    && (r_count < mhtc_pkg::CNT_W'(mhtc_pkg::HEADER_BYTES));
    // oldest byte on top, new byte in the low bits
    assign w_full = {r_win, i_item.data_byte};

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_win   = r_win;
        n_ogg   = r_ogg;
        if (w_take) begin
            if (r_count < mhtc_pkg::CNT_W'(mhtc_pkg::HEAD_LEN)) begin
                n_head[r_count[mhtc_pkg::HEAD_IDX_W-1:0]] = i_item.data_byte;
            end
            if (w_full == mhtc_pkg::SIG_OPUS
                || w_full[mhtc_pkg::WIN_LEN*8-1:0] == mhtc_pkg::SIG_VORBIS) begin
                n_ogg[mhtc_pkg::OGG_AUDIO_BIT] = 1'b1;
            end
            if (w_full[mhtc_pkg::WIN_LEN*8-1:0] == mhtc_pkg::SIG_THEORA) begin
                n_ogg[mhtc_pkg::OGG_VIDEO_BIT] = 1'b1;
            end
            n_win   = w_full[mhtc_pkg::WIN_LEN*8-1:0];
            n_count = r_count + mhtc_pkg::CNT_W'(1);
        end
    end

    assign w_class     = mhtc_pkg::classify(n_head, n_count, n_ogg);
    assign o_res_valid = i_fire && i_item.last;

    always_comb begin
        if (w_class != mhtc_pkg::CLS_UNKNOWN) begin
            o_res.media_class  = w_class;
            o_res.from_content = 1'b1;
        end else begin
            o_res.media_class  = i_item.ext_class;
            o_res.from_content = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_head  <= '0;
            r_count <= '0;
            r_win   <= '0;
            r_ogg   <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_win   <= n_win;
            r_ogg   <= n_ogg;
        end
    end

endmodule

// ===== src/mhtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// mhtc_out_stage
// Result register on the master side.
// ----------------------------------------------------------------------------
module mhtc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mhtc_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output mhtc_pkg::t_result o_res
);

    logic              r_valid;
    mhtc_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== src/media_header_type_classifier.sv =====
// ----------------------------------------------------------------------------
// media_header_type_classifier
// Sniffs the leading bytes of a file and reports its media class on the
// transaction marked last.
// ----------------------------------------------------------------------------
// the last transaction passes through the input register, and its result is then held in the result register
// throughput: one transaction per cycle; input register, one pass of compare
//   logic and the result register
// the input side stalls only when a last item meets a full result register
// reset: synchronous, active low; clears all header state and both valid bits
module media_header_type_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic [2:0] i_s_tuser,   // [0] has_byte, [2:1] ext_class
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [1:0] media_class, [7:2] zero
    output logic       o_m_tuser    // [0] from_content
);

    mhtc_pkg::t_item   w_s_item;
    mhtc_pkg::t_item   w_in_item;
    mhtc_pkg::t_result w_res;
    mhtc_pkg::t_result w_out_res;
    logic              w_in_valid;
    logic              w_fire;
    logic              w_out_free;
    logic              w_res_valid;

    assign w_s_item.data_byte = i_s_tdata;
    assign w_s_item.has_byte  = i_s_tuser[0];
    assign w_s_item.ext_class = i_s_tuser[2:1];
    assign w_s_item.last      = i_s_tlast;

    mhtc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_item     (w_s_item),
        .i_out_free (w_out_free),
        .o_valid    (w_in_valid),
        .o_fire     (w_fire),
        .o_item     (w_in_item)
    );

    mhtc_tracker u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_in_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mhtc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_out_res)
    );

    assign o_m_tdata = {6'd0, w_out_res.media_class};
    assign o_m_tuser = w_out_res.from_content;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_in_item.last |=> o_m_tvalid)
        else $error("last transaction produced no result");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_fire && w_in_item.last))
        else $error("result without a last transaction");

    a_content_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[1:0] != mhtc_pkg::CLS_UNKNOWN)
        else $error("content match reported as unknown");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> w_in_valid && w_in_item.last && o_m_tvalid)
        else $error("input stalled without a pending last item");

endmodule

// ===== bench/media_header_type_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// media_header_type_classifier_tb
// Streams short files byte by byte into the classifier and predicts the media
// class of each one from its own signature matcher. It covers short files,
// files longer than the kept header, empty closing transactions and ogg
// markers at random offsets, and runs under several mixes of input gaps and
// output back-pressure.
// ----------------------------------------------------------------------------
module media_header_type_classifier_tb;

    typedef enum int {
        F_NOISE, F_JPEG, F_PNG, F_GIF, F_BMP, F_TIFF_LE, F_TIFF_BE, F_FLV,
        F_EBML, F_TS, F_RIFF, F_FTYP, F_OGG, F_SHORT
    } t_file_kind;

    typedef struct {
        mhtc_pkg::t_item item;
        bit              wait_drain;
    } t_pending;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;       // [7:0] data_byte
    logic [2:0] s_tuser = '0;       // [0] has_byte, [2:1] ext_class
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [1:0] media_class, [7:2] zero
    logic       m_tuser;            // [0] from_content

    t_pending          byte_items_q[$];
    mhtc_pkg::t_result class_expect_q[$];
    logic [7:0]        fbuf[$];
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       useful_items = 0;
    int unsigned       err_count = 0;
    bit                s_taken = 1'b0;

    // predictor state
    logic [95:0] head_bits = '0;     // byte 0 in the top bits
    int unsigned kept_count = 0;
    logic [55:0] tail_bits = '0;     // newest kept byte in the low bits
    logic [1:0]  ogg_marks = '0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    media_header_type_classifier dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    function automatic void keep_byte(input logic [7:0] b);
        logic [63:0] w8;
        if (kept_count >= mhtc_pkg::HEADER_BYTES) return;
        if (kept_count < mhtc_pkg::HEAD_LEN) head_bits[95 - 8 * kept_count -: 8] = b;
        w8 = {tail_bits, b};
        if (w8 == mhtc_pkg::SIG_OPUS || w8[55:0] == mhtc_pkg::SIG_VORBIS)
            ogg_marks[mhtc_pkg::OGG_AUDIO_BIT] = 1'b1;
        if (w8[55:0] == mhtc_pkg::SIG_THEORA) ogg_marks[mhtc_pkg::OGG_VIDEO_BIT] = 1'b1;
        tail_bits = w8[55:0];
        kept_count++;
    endfunction

    function automatic logic [1:0] header_class();
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        w0 = head_bits[95:64];
        w1 = head_bits[63:32];
        w2 = head_bits[31:0];
        if (kept_count < 4) return mhtc_pkg::CLS_UNKNOWN;
        if (w0[31:8] == mhtc_pkg::SIG_JPEG) return mhtc_pkg::CLS_PHOTO;
        if (w0 == mhtc_pkg::SIG_PNG || w0 == mhtc_pkg::SIG_GIF) return mhtc_pkg::CLS_PHOTO;
        if (w0[31:16] == mhtc_pkg::SIG_BMP) return mhtc_pkg::CLS_PHOTO;
        if (w0 == mhtc_pkg::SIG_TIFF_LE || w0 == mhtc_pkg::SIG_TIFF_BE)
            return mhtc_pkg::CLS_PHOTO;
        if (w0 == mhtc_pkg::SIG_FLV || w0 == mhtc_pkg::SIG_EBML) return mhtc_pkg::CLS_VIDEO;
        if (w0[31:24] == mhtc_pkg::SIG_TS) return mhtc_pkg::CLS_VIDEO;
        if (kept_count >= mhtc_pkg::HEAD_LEN && w0 == mhtc_pkg::SIG_RIFF) begin
            if (w2 == mhtc_pkg::SIG_WEBP) return mhtc_pkg::CLS_PHOTO;
            if (w2 == mhtc_pkg::SIG_WAVE) return mhtc_pkg::CLS_AUDIO;
            if (w2 == mhtc_pkg::SIG_AVI) return mhtc_pkg::CLS_VIDEO;
        end
        if (kept_count >= mhtc_pkg::HEAD_LEN && w1 == mhtc_pkg::SIG_FTYP) begin
            case (w2)
                mhtc_pkg::SIG_HEIC, mhtc_pkg::SIG_HEIX, mhtc_pkg::SIG_MIF1,
                mhtc_pkg::SIG_HEIM, mhtc_pkg::SIG_HEIS, mhtc_pkg::SIG_AVIF,
                mhtc_pkg::SIG_AVIS:
                    return mhtc_pkg::CLS_PHOTO;
                mhtc_pkg::SIG_M4A: return mhtc_pkg::CLS_AUDIO;
                default: return mhtc_pkg::CLS_VIDEO;
            endcase
        end
        if (w0 == mhtc_pkg::SIG_OGGS) begin
            if (ogg_marks[mhtc_pkg::OGG_AUDIO_BIT]) return mhtc_pkg::CLS_AUDIO;
            if (ogg_marks[mhtc_pkg::OGG_VIDEO_BIT]) return mhtc_pkg::CLS_VIDEO;
        end
        return mhtc_pkg::CLS_UNKNOWN;
    endfunction

    function automatic void predict_class(input mhtc_pkg::t_item it);
        mhtc_pkg::t_result res;
        logic [1:0]        cls;
        if (it.has_byte) keep_byte(it.data_byte);
        if (!it.last) return;
        cls = header_class();
        if (cls != mhtc_pkg::CLS_UNKNOWN) begin
            res.media_class  = cls;
            res.from_content = 1'b1;
        end else begin
            res.media_class  = it.ext_class;
            res.from_content = 1'b0;
        end
        class_expect_q.push_back(res);
        head_bits  = '0;
        kept_count = 0;
        tail_bits  = '0;
        ogg_marks  = '0;
    endfunction

    // driver: new transaction only once the current one is gone
    always @(negedge clk) begin : drive_proc
        t_pending nxt;
        if (rst_n) begin
            if (!s_tvalid || s_taken) begin
                if (byte_items_q.size() != 0
                    && !(byte_items_q[0].wait_drain && class_expect_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_items_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.item.data_byte;
                    s_tuser  <= {nxt.item.ext_class, nxt.item.has_byte};
                    s_tlast  <= nxt.item.last;
                end else begin
                    // garbage on the bus while idle must be ignored
                    s_tvalid <= 1'b0;
                    s_tdata  <= 8'($urandom);
                    s_tuser  <= 3'($urandom);
                    s_tlast  <= 1'($urandom);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin : monitor_proc
        mhtc_pkg::t_item   it;
        mhtc_pkg::t_result want;
        s_taken = 1'b0;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                s_taken      = 1'b1;
                it.data_byte = s_tdata;
                it.has_byte  = s_tuser[0];
                it.ext_class = s_tuser[2:1];
                it.last      = s_tlast;
                predict_class(it);
            end
            if (m_tvalid && m_tready) begin
                if (class_expect_q.size() == 0) begin
                    $error("unexpected result: media_class %0d from_content %0d",
                           m_tdata[1:0], m_tuser);
                    err_count++;
                end else begin
                    want = class_expect_q.pop_front();
                    if (m_tdata[1:0] !== want.media_class) begin
                        $error("media_class: expected %0d, got %0d",
                               want.media_class, m_tdata[1:0]);
                        err_count++;
                    end
                    if (m_tuser !== want.from_content) begin
                        $error("from_content: expected %0d, got %0d",
                               want.from_content, m_tuser);
                        err_count++;
                    end
                end
            end
        end
    end

    task automatic push_item(input logic [7:0] b, input bit has, input bit lst,
                             input logic [1:0] ext, input bit drain);
        t_pending p;
        p.item.data_byte = b;
        p.item.has_byte  = has;
        p.item.last      = lst;
        p.item.ext_class = ext;
        p.wait_drain     = drain;
        byte_items_q.push_back(p);
        if (has || lst) useful_items++;
    endtask

    // queue the bytes in fbuf as one file, with the odd ignored transaction mixed in
    task automatic emit_file(input bit drain_first, input bit close_empty,
                             input logic [1:0] last_ext);
        bit first;
        int n;
        first = drain_first;
        n     = fbuf.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                push_item(8'($urandom), 1'b0, 1'b0, 2'($urandom), first);
                first = 1'b0;
            end
            push_item(fbuf[i], 1'b1, !close_empty && i == n - 1,
                      (!close_empty && i == n - 1) ? last_ext : 2'($urandom), first);
            first = 1'b0;
        end
        if (close_empty || n == 0) push_item(8'($urandom), 1'b0, 1'b1, last_ext, first);
    endtask

    task automatic fill_random(input int len);
        fbuf = {};
        for (int i = 0; i < len; i++) fbuf.push_back(8'($urandom));
    endtask

    // overlay an n-byte pattern, first byte in the top bits, clipped to the file
    task automatic put_bytes(input int pos, input logic [63:0] v, input int n);
        for (int k = 0; k < n; k++)
            if (pos + k < fbuf.size()) fbuf[pos + k] = v[8 * (n - 1 - k) +: 8];
    endtask

    task automatic put_marker(input logic [63:0] v, input int n);
        if (fbuf.size() - n >= 4) put_bytes($urandom_range(4, fbuf.size() - n), v, n);
    endtask

    task automatic make_random_file(input bit drain_first);
        t_file_kind  kind;
        int          len;
        int          pos;
        logic [31:0] brand;
        kind = t_file_kind'($urandom_range(F_SHORT));
        if (kind == F_SHORT) len = $urandom_range(3);
        else if ($urandom_range(11) == 0) len = $urandom_range(56, 80);
        else if (kind == F_OGG) len = $urandom_range(12, 40);
        else if (kind == F_RIFF || kind == F_FTYP) len = $urandom_range(10, 20);
        else len = $urandom_range(4, 16);
        fill_random(len);
        case (kind)
            F_SHORT:   if ($urandom_range(1)) put_bytes(0, 64'(mhtc_pkg::SIG_JPEG), 3);
            F_JPEG:    put_bytes(0, 64'(mhtc_pkg::SIG_JPEG), 3);
            F_PNG:     put_bytes(0, 64'(mhtc_pkg::SIG_PNG), 4);
            F_GIF:     put_bytes(0, 64'(mhtc_pkg::SIG_GIF), 4);
            F_BMP:     put_bytes(0, 64'(mhtc_pkg::SIG_BMP), 2);
            F_TIFF_LE: put_bytes(0, 64'(mhtc_pkg::SIG_TIFF_LE), 4);
            F_TIFF_BE: put_bytes(0, 64'(mhtc_pkg::SIG_TIFF_BE), 4);
            F_FLV:     put_bytes(0, 64'(mhtc_pkg::SIG_FLV), 4);
            F_EBML:    put_bytes(0, 64'(mhtc_pkg::SIG_EBML), 4);
            F_TS:      put_bytes(0, 64'(mhtc_pkg::SIG_TS), 1);
            F_RIFF: begin
                put_bytes(0, 64'(mhtc_pkg::SIG_RIFF), 4);
                case ($urandom_range(3))
                    0: put_bytes(8, 64'(mhtc_pkg::SIG_WEBP), 4);
                    1: put_bytes(8, 64'(mhtc_pkg::SIG_WAVE), 4);
                    2: put_bytes(8, 64'(mhtc_pkg::SIG_AVI), 4);
                    default: ;
                endcase
            end
            F_FTYP: begin
                case ($urandom_range(8))
                    0: brand = mhtc_pkg::SIG_HEIC;
                    1: brand = mhtc_pkg::SIG_HEIX;
                    2: brand = mhtc_pkg::SIG_MIF1;
                    3: brand = mhtc_pkg::SIG_HEIM;
                    4: brand = mhtc_pkg::SIG_HEIS;
                    5: brand = mhtc_pkg::SIG_AVIF;
                    6: brand = mhtc_pkg::SIG_AVIS;
                    7: brand = mhtc_pkg::SIG_M4A;
                    default: brand = $urandom;
                endcase
                put_bytes(4, 64'(mhtc_pkg::SIG_FTYP), 4);
                put_bytes(8, 64'(brand), 4);
            end
            F_OGG: begin
                put_bytes(0, 64'(mhtc_pkg::SIG_OGGS), 4);
                if ($urandom_range(1)) put_marker(mhtc_pkg::SIG_OPUS, 8);
                if ($urandom_range(1)) put_marker(64'(mhtc_pkg::SIG_VORBIS), 7);
                if ($urandom_range(1)) put_marker(64'(mhtc_pkg::SIG_THEORA), 7);
            end
            default: ;
        endcase
        // near miss: one flipped bit somewhere in the signature area
        if (kind != F_SHORT && $urandom_range(7) == 0) begin
            pos = $urandom_range(mhtc_pkg::HEAD_LEN - 1);
            if (pos < len) fbuf[pos] = fbuf[pos] ^ (8'h01 << $urandom_range(7));
        end
        emit_file(drain_first, len == 0 || $urandom_range(2) == 0, 2'($urandom_range(3)));
    endtask

    initial begin
        int target;

        // directed files
        fbuf = {};
        emit_file(1'b0, 1'b1, mhtc_pkg::CLS_UNKNOWN);
        fbuf = {8'hff, 8'hd8, 8'hff};
        emit_file(1'b0, 1'b0, mhtc_pkg::CLS_PHOTO);
        fbuf = {8'hff, 8'hd8, 8'hff, 8'h00};
        emit_file(1'b0, 1'b1, mhtc_pkg::CLS_VIDEO);
        fbuf = {8'hff, 8'hff, 8'hff, 8'hff};
        emit_file(1'b0, 1'b0, mhtc_pkg::CLS_AUDIO);
        fbuf = {8'h00, 8'h00, 8'h00, 8'h00};
        emit_file(1'b0, 1'b0, mhtc_pkg::CLS_UNKNOWN);
        fill_random(12);
        put_bytes(0, 64'(mhtc_pkg::SIG_RIFF), 4);
        put_bytes(8, 64'(mhtc_pkg::SIG_WAVE), 4);
        emit_file(1'b0, 1'b0, mhtc_pkg::CLS_UNKNOWN);

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            target = useful_items + 150;
            make_random_file(1'b1);
            while (useful_items < target) make_random_file($urandom_range(24) == 0);
            while (byte_items_q.size() != 0) @(posedge clk);
        end

        while (byte_items_q.size() != 0 || s_tvalid || class_expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mhtc_pkg.sv
src/mhtc_in_stage.sv
src/mhtc_tracker.sv
src/mhtc_out_stage.sv
src/media_header_type_classifier.sv
bench/media_header_type_classifier_tb.sv
